/* hw/rtl/bloom_filter_test_and_insert_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bloom filter core
// Concurrent checks clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_TEST_AND_INSERT_CORE_ASSERT_SVH
`define BLOOM_FILTER_TEST_AND_INSERT_CORE_ASSERT_SVH

// condition must never hold
`define BFTI_ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("bfti: forbidden condition seen");

// same-cycle implication
`define BFTI_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bfti: implication failed");

// next-cycle implication
`define BFTI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bfti: next-cycle implication failed");

`endif

/* hw/rtl/bfti_pkg.sv */
// ----------------------------------------------------------------------------
// bfti_pkg
// Shared types and constants of the bloom filter test-and-insert core.
// ----------------------------------------------------------------------------
package bfti_pkg;

    // digest half width
    localparam int DIGEST_W = 64;

    // configuration register widths
    localparam int BIT_COUNT_W   = 17;
    localparam int PROBE_COUNT_W = 5;
    localparam int CFG_DATA_W    = 17;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_BIT_COUNT   = 1'b0,
        REG_PROBE_COUNT = 1'b1
    } bfti_reg_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_WRAP,
        S_DIV_STEP,
        S_DIV_BASE,
        S_PROBE,
        S_DRAIN,
        S_SET,
        S_OUT
    } bfti_state_t;

endpackage

/* hw/rtl/bfti_mod_unit.sv */
// ----------------------------------------------------------------------------
// bfti_mod_unit
// Restoring remainder unit: 64-bit dividend modulo a narrow divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module bfti_mod_unit
    import bfti_pkg::*;
#(
    parameter int MW = 17
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DIGEST_W-1:0] dividend,
    input  logic [MW-1:0]       divisor,
    output logic                done,
    output logic [MW-1:0]       remainder
);

    localparam int CW = $clog2(DIGEST_W + 1);

    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [MW-1:0]       rem_reg;
    logic [DIGEST_W-1:0] quo_reg;
    logic [MW:0]         trial;
    logic [MW-1:0]       rem_step;

    // one shift-subtract step
    always_comb begin
        trial    = {rem_reg, quo_reg[DIGEST_W-1]};
        rem_step = (trial >= {1'b0, divisor}) ? MW'(trial - {1'b0, divisor}) : MW'(trial);
    end

    // step counter
    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next = CW'(DIGEST_W);
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // partial remainder and dividend shifter
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_step;
            quo_reg <= quo_reg << 1;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* hw/rtl/bloom_filter_test_and_insert_core.sv */
// Each word takes three remainder passes of the shared mod unit, which dominate, then
// one probe read per effective probe and a drain step, and for a new record one write
// per probe; with zero probes the probe phase is skipped.
// Throughput: one word at a time; the next word is taken after the result is taken.
// Reset: synchronous, active low; the bit store is then cleared one bit per cycle
// from address 0 up to MAX_BITS - 1, during which no word is accepted.
// ----------------------------------------------------------------------------
// bloom_filter_test_and_insert_core
// Bloom filter with double hashing: tests k probe bits, sets them all if any
// was clear, and reports the record as new or possibly seen.
// ----------------------------------------------------------------------------
module bloom_filter_test_and_insert_core
    import bfti_pkg::*;
#(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_PROBES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DIGEST_W-1:0]   s_digest_low,
    input  logic [DIGEST_W-1:0]   s_digest_high,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_was_new,
    output logic [DIGEST_W-1:0]   m_fingerprint
);

`include "bloom_filter_test_and_insert_core_assert.svh"

    // largest usable modulus, store address and counter widths
    localparam int MMAX = (MAX_BITS < 131071) ? MAX_BITS : 131071;
    localparam int MW   = $clog2(MMAX + 1);
    localparam int AW   = $clog2(MAX_BITS);
    localparam int KW   = $clog2(MAX_PROBES + 1);
    localparam int IW   = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;

    bfti_state_t state_reg, state_next;

    logic [BIT_COUNT_W-1:0]   bit_count_reg;
    logic [PROBE_COUNT_W-1:0] probe_count_reg;

    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [DIGEST_W-1:0] base_reg, base_next;
    logic [DIGEST_W-1:0] step_reg, step_next;
    logic [DIGEST_W-1:0] h_reg, h_next;
    logic [MW-1:0]       r_reg, r_next;
    logic [MW-1:0]       s_reg, s_next;
    logic [MW-1:0]       w_reg, w_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                any_clear_reg, any_clear_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                was_new_reg, was_new_next;
    logic                rd_data_reg;
    logic [AW-1:0]       pos_reg [MAX_PROBES];

    logic                filter_mem [MAX_BITS];
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic                mem_wdata;

    logic [MW-1:0]       m_eff;
    logic [KW-1:0]       k_eff;
    logic                idx_last;
    logic                hit;

    logic                div_start;
    logic [DIGEST_W-1:0] div_dividend;
    logic                div_done;
    logic [MW-1:0]       div_rem;

    logic [DIGEST_W:0]   h_sum;
    logic [MW:0]         t_sum;
    logic [MW-1:0]       t_mod;
    logic [MW-1:0]       r_adv;

    // effective modulus and probe count
    always_comb begin
        if (bit_count_reg == '0) begin
            m_eff = MW'(1);
        end else if (32'(bit_count_reg) > MAX_BITS) begin
            m_eff = MW'(MAX_BITS);
        end else begin
            m_eff = MW'(bit_count_reg);
        end
        k_eff    = (32'(probe_count_reg) > MAX_PROBES) ? KW'(MAX_PROBES) : KW'(probe_count_reg);
        idx_last = (KW'(idx_reg) == k_eff - KW'(1));
    end

    // next probe position: (r + s) mod m, less 2^64 mod m when the 64-bit sum wraps
    always_comb begin
        h_sum = {1'b0, h_reg} + {1'b0, step_reg};
        t_sum = {1'b0, r_reg} + {1'b0, s_reg};
        t_mod = (t_sum >= {1'b0, m_eff}) ? MW'(t_sum - {1'b0, m_eff}) : MW'(t_sum);
        if (!h_sum[DIGEST_W]) begin
            r_adv = t_mod;
        end else if (t_mod >= w_reg) begin
            r_adv = t_mod - w_reg;
        end else begin
            r_adv = MW'(({1'b0, t_mod} + {1'b0, m_eff}) - {1'b0, w_reg});
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_count_reg   <= BIT_COUNT_W'(65536);
            probe_count_reg <= PROBE_COUNT_W'(7);
        end else if (cfg_wr_en) begin
            case (bfti_reg_t'(cfg_index))
                REG_BIT_COUNT: begin
                    bit_count_reg <= cfg_data[BIT_COUNT_W-1:0];
                end
                REG_PROBE_COUNT: begin
                    probe_count_reg <= cfg_data[PROBE_COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // shared remainder unit
    bfti_mod_unit #(
        .MW (MW)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (m_eff),
        .done      (div_done),
        .remainder (div_rem)
    );

    // sequencer: next state and outputs
    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        base_next      = base_reg;
        step_next      = step_reg;
        h_next         = h_reg;
        r_next         = r_reg;
        s_next         = s_reg;
        w_next         = w_reg;
        idx_next       = idx_reg;
        any_clear_next = any_clear_reg;
        rd_valid_next  = rd_valid_reg;
        was_new_next   = was_new_reg;
        div_start      = 1'b0;
        div_dividend   = h_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg[idx_reg];
        mem_wdata      = 1'b1;
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        hit            = any_clear_reg | (rd_valid_reg & ~rd_data_reg);

        case (state_reg)
            S_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = 1'b0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAX_BITS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    base_next    = s_digest_low;
                    step_next    = s_digest_high;
                    h_next       = s_digest_low;
                    div_start    = 1'b1;
                    div_dividend = '1;
                    state_next   = S_DIV_WRAP;
                end
            end
            S_DIV_WRAP: begin
                // (2^64 - 1) mod m, plus one, gives 2^64 mod m
                if (div_done) begin
                    w_next       = (div_rem == m_eff - MW'(1)) ? '0 : div_rem + MW'(1);
                    div_start    = 1'b1;
                    div_dividend = step_reg;
                    state_next   = S_DIV_STEP;
                end
            end
            S_DIV_STEP: begin
                // step that is a multiple of m is bumped by one; all ones wraps to zero
                if (div_done) begin
                    if (div_rem == '0) begin
                        step_next = step_reg + DIGEST_W'(1);
                        s_next    = (m_eff == MW'(1) || step_reg == '1) ? '0 : MW'(1);
                    end else begin
                        s_next = div_rem;
                    end
                    div_start    = 1'b1;
                    div_dividend = h_reg;
                    state_next   = S_DIV_BASE;
                end
            end
            S_DIV_BASE: begin
                if (div_done) begin
                    r_next         = div_rem;
                    idx_next       = '0;
                    any_clear_next = 1'b0;
                    rd_valid_next  = 1'b0;
                    if (k_eff == '0) begin
                        was_new_next = 1'b0;
                        state_next   = S_OUT;
                    end else begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                // read at r, check previous read, advance the sequence
                rd_valid_next = 1'b1;
                r_next        = r_adv;
                h_next        = h_sum[DIGEST_W-1:0];
                if (rd_valid_reg && !rd_data_reg) begin
                    any_clear_next = 1'b1;
                end
                if (idx_last) begin
                    idx_next   = '0;
                    state_next = S_DRAIN;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_DRAIN: begin
                rd_valid_next  = 1'b0;
                any_clear_next = hit;
                was_new_next   = hit;
                state_next     = hit ? S_SET : S_OUT;
            end
            S_SET: begin
                mem_we = 1'b1;
                if (idx_last) begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            idx_reg       <= '0;
            any_clear_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            idx_reg       <= idx_next;
            any_clear_reg <= any_clear_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        base_reg    <= base_next;
        step_reg    <= step_next;
        h_reg       <= h_next;
        r_reg       <= r_next;
        s_reg       <= s_next;
        w_reg       <= w_next;
        was_new_reg <= was_new_next;
        if (state_reg == S_PROBE) begin
            pos_reg[idx_reg] <= AW'(r_reg);
        end
    end

    // bit store: one write port, registered read at the current probe
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            filter_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= filter_mem[AW'(r_reg)];
    end

    assign m_was_new     = was_new_reg;
    assign m_fingerprint = base_reg;

    // checks
    `BFTI_ASSERT_NEVER(a_one_word_in_flight, s_ready && m_valid)
    `BFTI_ASSERT_IMPL(a_mod_done_when_waited, div_done,
        state_reg == S_DIV_WRAP || state_reg == S_DIV_STEP || state_reg == S_DIV_BASE)
    `BFTI_ASSERT_IMPL(a_probe_index_in_range, state_reg == S_PROBE || state_reg == S_SET,
        KW'(idx_reg) < k_eff)
    `BFTI_ASSERT_NEXT(a_set_follows_miss, state_reg == S_DRAIN && hit,
        state_reg == S_SET && was_new_reg)

endmodule

/* tb/sv/bloom_filter_test_and_insert_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bloom_filter_test_and_insert_core_tb
// Drives digest words into the bloom filter core and checks each result word
// against a bit-accurate filter model that mirrors the store and the registers.
// The run covers register extremes, repeated records and random idling.
// ----------------------------------------------------------------------------
module bloom_filter_test_and_insert_core_tb;
    import bfti_pkg::*;

    localparam int FILTER_BITS   = 65536;
    localparam int FILTER_PROBES = 16;
    localparam int PHASE_WORDS   = 132;
    localparam int HOLD_CYCLES   = 3000;
    localparam int STALL_LIMIT   = 300000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        was_new;
        logic [63:0] fingerprint;
    } filter_verdict_t;

    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
    } digest_pair_t;

    // filter model: bit store, registers and the verdicts still owed by the core
    class filter_scoreboard;
        bit                      seen_bits[FILTER_BITS];
        logic [BIT_COUNT_W-1:0]   bit_count_q;
        logic [PROBE_COUNT_W-1:0] probe_count_q;
        filter_verdict_t         owed_q[$];
        int                      errors;

        function new();
            foreach (seen_bits[i]) seen_bits[i] = 1'b0;
            bit_count_q   = BIT_COUNT_W'(65536);
            probe_count_q = PROBE_COUNT_W'(7);
            errors        = 0;
        endfunction

        function void write_reg(bfti_reg_t idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_BIT_COUNT)
                bit_count_q = val[BIT_COUNT_W-1:0];
            else
                probe_count_q = val[PROBE_COUNT_W-1:0];
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // test-and-insert on the model store; the verdict is queued
        function void note_record(logic [63:0] low, logic [63:0] high);
            logic [63:0] modulus;
            logic [63:0] stride;
            logic [63:0] probe_hash;
            int unsigned probes;
            int unsigned pos[FILTER_PROBES];
            bit          any_clear;
            filter_verdict_t v;
            modulus = (bit_count_q == 0) ? 64'd1 : 64'(bit_count_q);
            if (modulus > 64'(FILTER_BITS))
                modulus = 64'(FILTER_BITS);
            probes = (probe_count_q > FILTER_PROBES) ? FILTER_PROBES : probe_count_q;
            stride = high;
            if (stride % modulus == 0)
                stride = stride + 64'd1;
            any_clear = 1'b0;
            for (int i = 0; i < probes; i++) begin
                probe_hash = low + 64'(i) * stride;
                pos[i] = int'(probe_hash % modulus);
                if (!seen_bits[pos[i]])
                    any_clear = 1'b1;
            end
            if (any_clear) begin
                for (int i = 0; i < probes; i++)
                    seen_bits[pos[i]] = 1'b1;
            end
            v.was_new     = any_clear;
            v.fingerprint = low;
            owed_q.insert(owed_q.size(), v);
        endfunction

        function void check_result(logic was_new, logic [63:0] fingerprint);
            filter_verdict_t v;
            if (owed_q.size() == 0) begin
                $error("result word with no record outstanding: fingerprint %h", fingerprint);
                errors++;
                return;
            end
            v = owed_q.pop_front();
            if (was_new !== v.was_new) begin
                $error("was_new mismatch: expected %0d, actual %0d", v.was_new, was_new);
                errors++;
            end
            if (fingerprint !== v.fingerprint) begin
                $error("fingerprint mismatch: expected %h, actual %h",
                       v.fingerprint, fingerprint);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [0:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [DIGEST_W-1:0]   s_digest_low;
    logic [DIGEST_W-1:0]   s_digest_high;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_was_new;
    logic [DIGEST_W-1:0]   m_fingerprint;

    filter_scoreboard sb;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               hold_req      = 0;
    int               hold_ack      = 0;
    int               hold_left     = 0;
    int               stall_cycles  = 0;
    digest_pair_t     batch_q[$];
    digest_pair_t     history_q[$];

    bloom_filter_test_and_insert_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_digest_low  (s_digest_low),
        .s_digest_high (s_digest_high),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_was_new     (m_was_new),
        .m_fingerprint (m_fingerprint)
    );

    always #5 aclk = ~aclk;

    // result side: random back-pressure, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_was_new, m_fingerprint);
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // writes both registers on back-to-back cycles; call only while idle
    task automatic set_config(logic [CFG_DATA_W-1:0] bits, logic [CFG_DATA_W-1:0] probes);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BIT_COUNT;
        cfg_data  <= bits;
        @(posedge aclk);
        sb.write_reg(REG_BIT_COUNT, bits);
        cfg_index <= REG_PROBE_COUNT;
        cfg_data  <= probes;
        @(posedge aclk);
        sb.write_reg(REG_PROBE_COUNT, probes);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // offers every word of batch_q in order, with random gaps on the input side
    task automatic send_batch();
        digest_pair_t w;
        while (batch_q.size() != 0) begin
            w = batch_q.pop_front();
            if ($urandom_range(99) < send_idle_pct) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
            end
            s_valid       <= 1'b1;
            s_digest_low  <= w.low;
            s_digest_high <= w.high;
            do @(posedge aclk); while (!s_ready);
            sb.note_record(w.low, w.high);
        end
        s_valid <= 1'b0;
    endtask

    // sender pauses until every verdict is back
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    function automatic digest_pair_t pair(logic [63:0] low, logic [63:0] high);
        digest_pair_t p;
        p.low  = low;
        p.high = high;
        return p;
    endfunction

    // appends one directed word to the batch
    function automatic void queue_pair(logic [63:0] low, logic [63:0] high);
        batch_q.insert(batch_q.size(), pair(low, high));
    endfunction

    // mostly fresh and repeated records, some steps that are multiples of the bit count and edge-value noise
    task automatic fill_random_batch(logic [CFG_DATA_W-1:0] bits);
        logic [63:0] modulus;
        logic [63:0] edge_vals[4];
        digest_pair_t p;
        int pick;
        modulus = (bits == 0) ? 64'd1 : ((bits > FILTER_BITS) ? 64'(FILTER_BITS) : 64'(bits));
        edge_vals[0] = 64'd0;
        edge_vals[1] = ALL_ONES;
        edge_vals[2] = 64'h8000_0000_0000_0000;
        for (int n = 0; n < PHASE_WORDS; n++) begin
            edge_vals[3] = rand64();
            pick = $urandom_range(99);
            if (pick < 55 || history_q.size() == 0) begin
                p = pair(rand64(), rand64());
                history_q.insert(history_q.size(), p);
                if (history_q.size() > 256)
                    void'(history_q.pop_front());
            end else if (pick < 85) begin
                p = history_q[$urandom_range(history_q.size() - 1)];
            end else if (pick < 93) begin
                p = pair(rand64(), modulus * {32'd0, $urandom});
            end else begin
                p = pair(edge_vals[$urandom_range(3)], edge_vals[$urandom_range(3)]);
            end
            batch_q.insert(batch_q.size(), p);
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] bits;
        logic [CFG_DATA_W-1:0] probes;
        sb = new();
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_BIT_COUNT;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_digest_low  <= '0;
        s_digest_high <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, zero and all-ones fields, step multiple of bit count
        queue_pair(64'd0, 64'd0);
        queue_pair(ALL_ONES, ALL_ONES);
        queue_pair(64'd0, 64'h0000_0000_0001_0000);
        queue_pair(64'd0, 64'd0);
        queue_pair(ALL_ONES, ALL_ONES);
        queue_pair(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        send_batch();
        wait_drained();

        // bit count zero acts as one
        set_config(17'd0, 17'd16);
        queue_pair(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        queue_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_batch();
        wait_drained();

        // both counts above their maximum saturate
        set_config(17'h1_FFFF, 17'd31);
        queue_pair(ALL_ONES, 64'd0);
        queue_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        queue_pair(ALL_ONES, 64'd0);
        send_batch();
        wait_drained();

        // zero probes: never new
        set_config(17'd65536, 17'd0);
        queue_pair(64'h7777_0000_7777_0000, 64'd7);
        send_batch();
        wait_drained();

        // probe count with dropped upper bits; all-ones step wraps to zero at 65535
        set_config(17'd65535, 17'h1_FFE1);
        queue_pair(ALL_ONES, ALL_ONES);
        queue_pair(64'h0000_0000_0000_FFFE, ALL_ONES);
        send_batch();
        wait_drained();

        // random phases: sender-light, then receiver-light, then no idling
        for (int ph = 0; ph < 12; ph++) begin
            send_idle_pct = (ph < 4) ? 20 : ((ph < 8) ? 60 : 0);
            recv_idle_pct = (ph < 4) ? 60 : ((ph < 8) ? 20 : 0);
            case (ph)
                0:  begin bits = 17'd65536; probes = 17'd7;  end
                1:  begin bits = 17'd64;    probes = 17'd3;  end
                2:  begin bits = 17'($urandom_range(65536, 1)); probes = 17'($urandom_range(16, 1)); end
                3:  begin bits = 17'd1;     probes = 17'd16; end
                4:  begin bits = 17'd0;     probes = 17'd2;  end
                5:  begin bits = 17'($urandom_range(131071, 65537)); probes = 17'd31; end
                6:  begin bits = 17'($urandom_range(4096, 2)); probes = 17'($urandom_range(31, 0)); end
                7:  begin bits = 17'd65536; probes = 17'd16; end
                8:  begin bits = 17'd1000;  probes = 17'd4;  end
                9:  begin bits = 17'($urandom); probes = 17'($urandom); end
                10: begin bits = 17'd65535; probes = 17'd1;  end
                default: begin bits = 17'd65536; probes = 17'd7; end
            endcase
            set_config(bits, probes);
            fill_random_batch(bits);
            // long receiver hold-off so the core backs up its input
            if (ph == 1 || ph == 9)
                hold_req = hold_req + 1;
            send_batch();
            wait_drained();
        end

        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bfti_pkg.sv
hw/rtl/bfti_mod_unit.sv
hw/rtl/bloom_filter_test_and_insert_core.sv
tb/sv/bloom_filter_test_and_insert_core_tb.sv
